// ===== rtl/ukt_pkg.sv =====
`timescale 1ns / 1ps

package ukt_pkg;

  // Field widths fixed by the command and result formats
  localparam int unsigned KEY_W       = 40;
  localparam int unsigned TYPE_W      = 2;
  localparam int unsigned OUT_CNT_W   = 5;
  localparam int unsigned DEF_CAPACITY = 16;

  // Type tags that have a total of their own (tag three has none)
  localparam logic [TYPE_W-1:0] TYPE_CAR   = 2'd0;
  localparam logic [TYPE_W-1:0] TYPE_TRUCK = 2'd1;
  localparam logic [TYPE_W-1:0] TYPE_MOTO  = 2'd2;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_FULL   = 2'd1,
    ST_DUP    = 2'd2,
    ST_ABSENT = 2'd3
  } status_e;

  // One command beat
  typedef struct packed {
    op_e               opcode;
    logic [KEY_W-1:0]  key;
    logic [TYPE_W-1:0] entry_type;
  } cmd_t;

  // One result beat
  typedef struct packed {
    status_e              status;
    logic [OUT_CNT_W-1:0] fill_count;
    logic                 is_full;
    logic [OUT_CNT_W-1:0] car_total;
    logic [OUT_CNT_W-1:0] truck_total;
    logic [OUT_CNT_W-1:0] moto_total;
  } res_t;

  // Contents of one table slot, handed from a cell to its lower neighbor
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [TYPE_W-1:0] etype;
  } entry_t;

  // Write strobes broadcast to every cell
  typedef struct packed {
    logic ins_we;
    logic del_we;
  } cell_ctl_t;

endpackage

// ===== rtl/ukt_cell.sv =====
`timescale 1ns / 1ps

// One table slot: holds an entry, compares it against the command key,
// and on a delete takes over the entry of its upper neighbor.
module ukt_cell import ukt_pkg::*; #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned IDX_W = 4,
  parameter int unsigned CNT_W = 5
) (
  input  logic             clk_i,
  input  cell_ctl_t        ctl_i,
  input  logic [KEY_W-1:0] key_i,
  input  logic [TYPE_W-1:0] etype_i,
  input  logic [CNT_W-1:0] count_i,
  input  logic [IDX_W-1:0] pos_i,
  input  entry_t           next_i,
  output entry_t           entry_o,
  output logic             hit_o
);

  entry_t entry_q, entry_d;
  logic   occ;

  // Slot is live when it sits below the fill count
  assign occ   = (CNT_W'(IDX) < count_i);
  assign hit_o = occ && (entry_q.key == key_i);

  // Append at the fill point, or close the gap above a deleted slot
  always_comb begin
    entry_d = entry_q;
    if (ctl_i.ins_we && (CNT_W'(IDX) == count_i)) begin
      entry_d.key   = key_i;
      entry_d.etype = etype_i;
    end else if (ctl_i.del_we && (IDX_W'(IDX) >= pos_i)) begin
      entry_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ===== rtl/unique_key_table_with_type_counts.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake           Payload
// command   in         start & !busy       cmd_i  (opcode, key, entry_type)
// result    out        done_o, one cycle   res_o  (status, counts, full flag)
//
// Each command is registered at the accept edge; at the update edge that
// follows, the key compare runs in all cells at once and updates the table.
// The result beat is registered at that update edge; while it shows, a new
// command may already be accepted, but never while busy is high.
// Reset empties the table and clears the totals; no sweep is needed.
// The receiver cannot stall; done_o lasts exactly one cycle.
module unique_key_table_with_type_counts import ukt_pkg::*; #(
  parameter int unsigned CAPACITY = DEF_CAPACITY
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  cmd_t cmd_i,
  output logic done_o,
  output res_t res_o
);

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic busy_q, done_q;
  cmd_t cmd_q;
  res_t res_q, res_d;

  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] car_q, car_d, truck_q, truck_d, moto_q, moto_d;

  entry_t            entries [CAPACITY];
  entry_t            nexts   [CAPACITY];
  logic [CAPACITY-1:0] hits;
  logic [IDX_W-1:0]  pos;
  logic [TYPE_W-1:0] hit_type;
  logic              any_hit;
  logic              is_full_now;
  cell_ctl_t         ctl;

  // Command register and busy/done sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= start && !busy_q;
      done_q <= busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy_q) begin
      cmd_q <= cmd_i;
    end
  end

  // Row of cells; the top cell takes an empty entry on a delete
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i + 1 < CAPACITY) begin : g_nb
      assign nexts[i] = entries[i+1];
    end else begin : g_top
      assign nexts[i] = '0;
    end

    ukt_cell #(
      .IDX   (i),
      .IDX_W (IDX_W),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .key_i   (cmd_q.key),
      .etype_i (cmd_q.entry_type),
      .count_i (count_q),
      .pos_i   (pos),
      .next_i  (nexts[i]),
      .entry_o (entries[i]),
      .hit_o   (hits[i])
    );
  end

  // Stored keys are unique, so at most one cell hits: OR gives its place
  always_comb begin
    pos      = '0;
    hit_type = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (hits[i]) begin
        pos      = pos | IDX_W'(i);
        hit_type = hit_type | entries[i].etype;
      end
    end
  end

  assign any_hit     = |hits;
  assign is_full_now = (count_q >= CNT_W'(CAPACITY));

  // Decide the command and the table writes
  always_comb begin
    ctl            = '0;
    res_d.status   = ST_DONE;
    count_d        = count_q;
    car_d          = car_q;
    truck_d        = truck_q;
    moto_d         = moto_q;
    if (cmd_q.opcode == OP_INSERT) begin
      if (is_full_now) begin
        res_d.status = ST_FULL;
      end else if (any_hit) begin
        res_d.status = ST_DUP;
      end else begin
        ctl.ins_we = busy_q;
        count_d    = count_q + 1'b1;
        case (cmd_q.entry_type)
          TYPE_CAR:   car_d   = car_q + 1'b1;
          TYPE_TRUCK: truck_d = truck_q + 1'b1;
          TYPE_MOTO:  moto_d  = moto_q + 1'b1;
          default:    ;
        endcase
      end
    end else begin
      if (!any_hit) begin
        res_d.status = ST_ABSENT;
      end else begin
        ctl.del_we = busy_q;
        count_d    = count_q - 1'b1;
        case (hit_type)
          TYPE_CAR:   car_d   = car_q - 1'b1;
          TYPE_TRUCK: truck_d = truck_q - 1'b1;
          TYPE_MOTO:  moto_d  = moto_q - 1'b1;
          default:    ;
        endcase
      end
    end
    res_d.fill_count  = OUT_CNT_W'(count_d);
    res_d.is_full     = (count_d == CNT_W'(CAPACITY));
    res_d.car_total   = OUT_CNT_W'(car_d);
    res_d.truck_total = OUT_CNT_W'(truck_d);
    res_d.moto_total  = OUT_CNT_W'(moto_d);
  end

  // Fill count and per-type totals
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      car_q   <= '0;
      truck_q <= '0;
      moto_q  <= '0;
    end else if (busy_q) begin
      count_q <= count_d;
      car_q   <= car_d;
      truck_q <= truck_d;
      moto_q  <= moto_d;
    end
  end

  // Result beat register
  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      res_q <= res_d;
    end
  end

  assign busy   = busy_q;
  assign done_o = done_q;
  assign res_o  = res_q;

  // Checks
  a_two_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |=> (!busy_q && done_q))
    else $error("command did not finish in two cycles");

  a_no_extra_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("result beat without a command");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("fill count beyond capacity");

  a_totals_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((CNT_W+2)'(car_q) + (CNT_W+2)'(truck_q) + (CNT_W+2)'(moto_q))
      <= (CNT_W+2)'(count_q))
    else $error("type totals exceed fill count");

endmodule

// ===== bench/unique_key_table_with_type_counts_test.sv =====
`timescale 1ns / 1ps

module unique_key_table_with_type_counts_test;
  import ukt_pkg::*;

  localparam int unsigned CAP         = DEF_CAPACITY;
  localparam int unsigned POOL_SIZE   = 24;
  localparam int unsigned RAND_ITEMS  = 600;
  localparam int unsigned STALL_LIMIT = 2000;

  // Shadow copy of the key table; predicts one result beat per command
  class key_table_scoreboard;
    logic [KEY_W-1:0]  keys[CAP];
    logic [TYPE_W-1:0] tags[CAP];
    int                fill;
    int                type_totals[3];
    res_t              pending[$];
    int                mismatches;

    function new();
      fill = 0;
      mismatches = 0;
      foreach (type_totals[i]) type_totals[i] = 0;
    endfunction

    // Tag three has no total; totals never go below zero
    function void adjust_total(logic [TYPE_W-1:0] tag, bit add);
      if (tag == TYPE_CAR || tag == TYPE_TRUCK || tag == TYPE_MOTO) begin
        if (add) begin
          type_totals[tag]++;
        end else if (type_totals[tag] > 0) begin
          type_totals[tag]--;
        end
      end
    endfunction

    // Apply one accepted command and queue the result it must produce
    function void note_command(cmd_t c);
      res_t r;
      int   hit;
      hit = -1;
      for (int i = 0; i < fill; i++) begin
        if (hit < 0 && keys[i] == c.key) hit = i;
      end
      r.status = ST_DONE;
      if (c.opcode == OP_INSERT) begin
        if (fill >= CAP) begin
          r.status = ST_FULL;
        end else if (hit >= 0) begin
          r.status = ST_DUP;
        end else begin
          keys[fill] = c.key;
          tags[fill] = c.entry_type;
          fill++;
          adjust_total(c.entry_type, 1'b1);
        end
      end else if (hit < 0) begin
        r.status = ST_ABSENT;
      end else begin
        adjust_total(tags[hit], 1'b0);
        // compact: later entries move down one slot
        for (int i = hit; i < fill - 1; i++) begin
          keys[i] = keys[i+1];
          tags[i] = tags[i+1];
        end
        fill--;
      end
      r.fill_count  = OUT_CNT_W'(fill);
      r.is_full     = (fill == CAP);
      r.car_total   = OUT_CNT_W'(type_totals[TYPE_CAR]);
      r.truck_total = OUT_CNT_W'(type_totals[TYPE_TRUCK]);
      r.moto_total  = OUT_CNT_W'(type_totals[TYPE_MOTO]);
      pending.push_back(r);
    endfunction

    task report(string field, int got, int want);
      $display("[%0t] result mismatch on %s: got %0d, expected %0d", $realtime, field, got,
               want);
      mismatches++;
    endtask

    // Compare one result beat with the oldest prediction
    task check_result(res_t got);
      res_t want;
      if (pending.size() == 0) begin
        // beat with no command outstanding
        report("outstanding beats", 1, 0);
      end else begin
        want = pending.pop_front();
        if (got.status !== want.status) report("status", got.status, want.status);
        if (got.fill_count !== want.fill_count)
          report("fill_count", got.fill_count, want.fill_count);
        if (got.is_full !== want.is_full) report("is_full", got.is_full, want.is_full);
        if (got.car_total !== want.car_total)
          report("car_total", got.car_total, want.car_total);
        if (got.truck_total !== want.truck_total)
          report("truck_total", got.truck_total, want.truck_total);
        if (got.moto_total !== want.moto_total)
          report("moto_total", got.moto_total, want.moto_total);
      end
    endtask
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  logic busy;
  cmd_t cmd_i  = '0;
  logic done_o;
  res_t res_o;

  key_table_scoreboard sb = new();
  logic [KEY_W-1:0]    key_pool[POOL_SIZE];
  int                  stall_cycles = 0;
  bit                  idle_on = 1'b1;

  unique_key_table_with_type_counts uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .cmd_i (cmd_i),
    .done_o(done_o),
    .res_o (res_o)
  );

  always #1 clk_i = ~clk_i;

  // Result monitor: sample the beat at the edge that ends its cycle
  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(res_o);
  end

  // Watchdog: cycles with neither a command nor a result beat
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("[%0t] watchdog expired", $realtime);
      $display("end of test: mismatches");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic cmd_t make_cmd(op_e op, logic [KEY_W-1:0] k, logic [TYPE_W-1:0] t);
    cmd_t c;
    c.opcode     = op;
    c.key        = k;
    c.entry_type = t;
    return c;
  endfunction

  function automatic logic [KEY_W-1:0] any_key();
    return KEY_W'({$urandom(), $urandom()});
  endfunction

  // Present one command, optionally after a random gap, and hold it until taken
  task automatic send_command(cmd_t c);
    if (idle_on && $urandom_range(0, 99) < 31) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= c;
    do @(posedge clk_i); while (busy);
    sb.note_command(c);
  endtask

  // Random insert key: mostly from the pool, sometimes a stored one
  function automatic logic [KEY_W-1:0] insert_key();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 25 && sb.fill > 0) return sb.keys[$urandom_range(0, sb.fill - 1)];
    if (pick < 85) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    return any_key();
  endfunction

  // Random delete key: mostly one that is stored
  function automatic logic [KEY_W-1:0] delete_key();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 65 && sb.fill > 0) return sb.keys[$urandom_range(0, sb.fill - 1)];
    if (pick < 90) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    return any_key();
  endfunction

  initial begin
    bit filling;
    foreach (key_pool[i]) key_pool[i] = any_key();

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty delete, key extremes, every tag, duplicates, full table
    send_command(make_cmd(OP_DELETE, '0, 2'd0));
    send_command(make_cmd(OP_INSERT, '0, TYPE_CAR));
    send_command(make_cmd(OP_INSERT, '1, TYPE_TRUCK));
    send_command(make_cmd(OP_INSERT, '0, TYPE_MOTO));
    for (int i = 2; i < CAP; i++) begin
      send_command(make_cmd(OP_INSERT, KEY_W'(i * 40'h01_0203_0405), TYPE_W'(i % 4)));
    end
    send_command(make_cmd(OP_INSERT, 40'hAA_5555_AAAA, TYPE_CAR));
    send_command(make_cmd(OP_INSERT, '1, TYPE_CAR));
    send_command(make_cmd(OP_DELETE, KEY_W'(7 * 40'h01_0203_0405), 2'd3));
    send_command(make_cmd(OP_DELETE, '0, TYPE_MOTO));
    send_command(make_cmd(OP_DELETE, 40'h12_3456_789A, TYPE_CAR));
    send_command(make_cmd(OP_DELETE, KEY_W'((CAP - 1) * 40'h01_0203_0405), TYPE_TRUCK));

    // Random: alternating fill and drain phases over a small key pool
    filling = 1'b0;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 40 == 0) filling = !filling;
      idle_on = !(n >= 200 && n < 350);
      if ($urandom_range(0, 99) < (filling ? 80 : 25)) begin
        send_command(make_cmd(OP_INSERT, insert_key(), TYPE_W'($urandom_range(0, 3))));
      end else begin
        send_command(make_cmd(OP_DELETE, delete_key(), TYPE_W'($urandom_range(0, 3))));
      end
    end
    start <= 1'b0;

    // Drain outstanding results, then a short settle
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== unique_key_table_with_type_counts.f =====
rtl/ukt_pkg.sv
rtl/ukt_cell.sv
rtl/unique_key_table_with_type_counts.sv
bench/unique_key_table_with_type_counts_test.sv
